@@ design/bsc_pkg.sv @@
`default_nettype none
package bsc_pkg;

    localparam int unsigned CFG_REGS = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_T1_T2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T3_P1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 3'd5;

    localparam int unsigned DIV_STEPS = 64;

    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [31:0] temp;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic [31:0] temp;
        logic [19:0] adcp;
    } t_carry;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

@@ design/bsc_mul64.sv @@
`default_nettype none
module bsc_mul64 (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic [63:0]      o_p
);
    // low 64 bits of the product, two stages
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] n_ll;
    logic [31:0] n_lh;
    logic [31:0] n_hl;

    assign n_ll = {32'b0, i_a[31:0]} * {32'b0, i_b[31:0]};
    assign n_lh = i_a[31:0] * i_b[63:32];
    assign n_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            o_p  <= r_ll + {r_lh + r_hl, 32'b0};
        end
    end
endmodule
`default_nettype wire

@@ design/bsc_div64.sv @@
`default_nettype none
module bsc_div64 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [63:0]  i_num,
    input  wire logic [63:0]  i_den,
    input  wire bsc_pkg::t_side i_side,
    output logic [63:0]       o_q,
    output bsc_pkg::t_side    o_side
);
    typedef struct packed {
        logic [64:0]    rem;
        logic [63:0]    num;
        logic [63:0]    den;
        logic           neg;
        bsc_pkg::t_side side;
    } t_div_st;

    t_div_st r_st [0:bsc_pkg::DIV_STEPS];
    t_div_st n_st [1:bsc_pkg::DIV_STEPS];

    always_comb begin
        for (int k = 0; k < bsc_pkg::DIV_STEPS; k++) begin
            n_st[k+1] = r_st[k];
            n_st[k+1].rem = {r_st[k].rem[63:0], r_st[k].num[63]};
            if (n_st[k+1].rem >= {1'b0, r_st[k].den}) begin
                n_st[k+1].rem = n_st[k+1].rem - {1'b0, r_st[k].den};
                n_st[k+1].num = {r_st[k].num[62:0], 1'b1};
            end else begin
                n_st[k+1].num = {r_st[k].num[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= bsc_pkg::DIV_STEPS; k++) begin
                r_st[k].side.valid <= 1'b0;
            end
            o_side.valid <= 1'b0;
        end else if (i_en) begin
            r_st[0].rem  <= 65'd0;
            r_st[0].num  <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_st[0].den  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_st[0].neg  <= i_num[63] ^ i_den[63];
            r_st[0].side <= i_side;
            for (int k = 1; k <= bsc_pkg::DIV_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
            o_q    <= r_st[bsc_pkg::DIV_STEPS].neg ? (64'd0 - r_st[bsc_pkg::DIV_STEPS].num)
                                                   : r_st[bsc_pkg::DIV_STEPS].num;
            o_side <= r_st[bsc_pkg::DIV_STEPS].side;
        end
    end
endmodule
`default_nettype wire

@@ design/barometric_sensor_compensation.sv @@
`default_nettype none
// Pipelined sensor compensation: one temperature/pressure pair per cycle. The
// pipeline holds a 66-stage radix-2 divider and 64-bit multipliers built as
// two-stage 32-bit partial products. A two-entry output queue lets the pipeline
// keep running while one result waits; when the queue is full the whole pipeline
// holds and s_axis_tready drops. Calibration registers are to be written only
// while no item is in flight; the block itself does not enforce it.
module barometric_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // adc_temperature[19:0], adc_pressure[39:20]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
    output logic [0:0]       m_axis_tuser    // pressure_valid[0]
);
    logic [31:0] r_cal [0:bsc_pkg::CFG_REGS-1];
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bsc_pkg::CFG_REGS; k++) r_cal[k] <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bsc_pkg::REG_T1_T2: r_cal[0] <= i_cfg_data;
                bsc_pkg::REG_T3_P1: r_cal[1] <= i_cfg_data;
                bsc_pkg::REG_P2_P3: r_cal[2] <= i_cfg_data;
                bsc_pkg::REG_P4_P5: r_cal[3] <= i_cfg_data;
                bsc_pkg::REG_P6_P7: r_cal[4] <= i_cfg_data;
                bsc_pkg::REG_P8_P9: r_cal[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'b0, r_cal[0][15:0]};
    assign t2 = {{16{r_cal[0][31]}}, r_cal[0][31:16]};
    assign t3 = {{16{r_cal[1][15]}}, r_cal[1][15:0]};
    assign p1 = {48'b0, r_cal[1][31:16]};
    assign p2 = bsc_pkg::sx16(r_cal[2][15:0]);
    assign p3 = bsc_pkg::sx16(r_cal[2][31:16]);
    assign p4 = bsc_pkg::sx16(r_cal[3][15:0]);
    assign p5 = bsc_pkg::sx16(r_cal[3][31:16]);
    assign p6 = bsc_pkg::sx16(r_cal[4][15:0]);
    assign p7 = bsc_pkg::sx16(r_cal[4][31:16]);
    assign p8 = bsc_pkg::sx16(r_cal[5][15:0]);
    assign p9 = bsc_pkg::sx16(r_cal[5][31:16]);

    // side line, stage k+1 in r_cy[k]
    bsc_pkg::t_carry r_cy [0:13];

    logic [31:0] r_a0, r_d, r_ma, r_dd, r_a, r_e, r_a4, r_b0, r_fine;
    logic [63:0] r_x1;
    logic [31:0] n_fine5;
    logic [31:0] n_temp;

    assign n_fine5 = {r_fine[29:0], 2'b00} + r_fine + 32'd128;
    assign n_temp  = 32'($signed(n_fine5) >>> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 14; k++) r_cy[k].valid <= 1'b0;
        end else if (en) begin
            r_cy[0].valid <= s_axis_tvalid;
            r_cy[0].temp  <= 32'd0;
            r_cy[0].adcp  <= s_axis_tdata[39:20];
            for (int k = 1; k < 14; k++) begin
                if (k == 5) begin
                    r_cy[k].valid <= r_cy[k-1].valid;
                    r_cy[k].temp  <= n_temp;
                    r_cy[k].adcp  <= r_cy[k-1].adcp;
                end else begin
                    r_cy[k] <= r_cy[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0   <= {15'b0, s_axis_tdata[19:3]} - {t1[30:0], 1'b0};
            r_d    <= {16'b0, s_axis_tdata[19:4]} - t1;
            r_ma   <= r_a0 * t2;
            r_dd   <= r_d * r_d;
            r_a    <= 32'($signed(r_ma) >>> 11);
            r_e    <= 32'($signed(r_dd) >>> 12);
            r_a4   <= r_a;
            r_b0   <= r_e * t3;
            r_fine <= r_a4 + 32'($signed(r_b0) >>> 14);
            r_x1   <= {{32{r_fine[31]}}, r_fine} - 64'd128000;
        end
    end

    logic [63:0] w_sq, w_m5, w_m2, w_a6, w_a3, w_z, w_num;
    logic [63:0] r_m5d [0:1];
    logic [63:0] r_m2d [0:1];
    logic [63:0] r_x2, r_y, r_n0, r_yp;
    logic [63:0] w_pr;

    bsc_mul64 u_m_sq (.i_clk, .i_en(en), .i_a(r_x1), .i_b(r_x1), .o_p(w_sq));
    bsc_mul64 u_m_p5 (.i_clk, .i_en(en), .i_a(r_x1), .i_b(p5),   .o_p(w_m5));
    bsc_mul64 u_m_p2 (.i_clk, .i_en(en), .i_a(r_x1), .i_b(p2),   .o_p(w_m2));
    bsc_mul64 u_m_p6 (.i_clk, .i_en(en), .i_a(w_sq), .i_b(p6),   .o_p(w_a6));
    bsc_mul64 u_m_p3 (.i_clk, .i_en(en), .i_a(w_sq), .i_b(p3),   .o_p(w_a3));

    assign w_pr = 64'd1048576 - {44'b0, r_cy[10].adcp};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m5d[0] <= w_m5;
            r_m5d[1] <= r_m5d[0];
            r_m2d[0] <= w_m2;
            r_m2d[1] <= r_m2d[0];
            r_x2 <= w_a6 + {r_m5d[1][46:0], 17'b0} + {p4[28:0], 35'b0};
            r_y  <= 64'($signed(w_a3) >>> 8) + {r_m2d[1][51:0], 12'b0};
            r_n0 <= {w_pr[32:0], 31'b0} - r_x2;
            r_yp <= r_y + {16'b0, 1'b1, 47'b0};
        end
    end

    bsc_mul64 u_m_p1 (.i_clk, .i_en(en), .i_a(r_yp), .i_b(p1),       .o_p(w_z));
    bsc_mul64 u_m_k  (.i_clk, .i_en(en), .i_a(r_n0), .i_b(64'd3125), .o_p(w_num));

    logic [63:0]    w_den;
    bsc_pkg::t_side w_dside;
    logic [63:0]    w_q;
    bsc_pkg::t_side w_qside;

    assign w_den         = 64'($signed(w_z) >>> 33);
    assign w_dside.valid = r_cy[13].valid;
    assign w_dside.zero  = (w_den == 64'd0);
    assign w_dside.temp  = r_cy[13].temp;

    bsc_div64 u_div (
        .i_clk, .i_rst_n, .i_en(en),
        .i_num(w_num), .i_den(w_den), .i_side(w_dside),
        .o_q(w_q), .o_side(w_qside)
    );

    logic [63:0] w_h, w_hh, w_m8, w_m9;
    assign w_h = 64'($signed(w_q) >>> 13);

    bsc_mul64 u_m_hh (.i_clk, .i_en(en), .i_a(w_h),  .i_b(w_h), .o_p(w_hh));
    bsc_mul64 u_m_p8 (.i_clk, .i_en(en), .i_a(w_q),  .i_b(p8),  .o_p(w_m8));
    bsc_mul64 u_m_p9 (.i_clk, .i_en(en), .i_a(w_hh), .i_b(p9),  .o_p(w_m9));

    logic [63:0]    r_qd [0:3];
    logic [63:0]    r_m8d [0:1];
    bsc_pkg::t_side r_sd [0:3];
    logic [63:0]    r_sum;
    bsc_pkg::t_side r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_sd[k].valid <= 1'b0;
            r_sv.valid <= 1'b0;
        end else if (en) begin
            r_qd[0]  <= w_q;
            r_sd[0]  <= w_qside;
            for (int k = 1; k < 4; k++) begin
                r_qd[k] <= r_qd[k-1];
                r_sd[k] <= r_sd[k-1];
            end
            r_m8d[0] <= w_m8;
            r_m8d[1] <= r_m8d[0];
            r_sum <= r_qd[3] + 64'($signed(w_m9) >>> 25) + 64'($signed(r_m8d[1]) >>> 19);
            r_sv  <= r_sd[3];
        end
    end

    logic [63:0] w_fin;
    logic [31:0] w_press;
    logic        w_pvalid;
    assign w_fin = 64'($signed(r_sum) >>> 8) + {p7[59:0], 4'b0};

    always_comb begin
        if (r_sv.zero) begin
            w_press  = 32'd0;
            w_pvalid = 1'b0;
        end else begin
            w_pvalid = 1'b1;
            if (w_fin[63]) w_press = 32'd0;
            else if (w_fin[63:32] != 32'd0) w_press = 32'hFFFF_FFFF;
            else w_press = w_fin[31:0];
        end
    end

    // two-entry output queue
    logic [64:0] r_q0, r_q1;
    logic [1:0]  r_cnt;
    logic        push, pop;
    logic [64:0] w_item;

    assign en     = (r_cnt != 2'd2);
    assign push   = en && r_sv.valid;
    assign pop    = m_axis_tvalid && m_axis_tready;
    assign w_item = {w_pvalid, w_press, r_sv.temp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_q0 <= (r_cnt == 2'd2) ? r_q1 : w_item;
                if (push && r_cnt == 2'd2) r_q1 <= w_item;
            end else if (push) begin
                if (r_cnt == 2'd0) r_q0 <= w_item;
                else r_q1 <= w_item;
            end
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0[63:0];
    assign m_axis_tuser  = r_q0[64];
endmodule
`default_nettype wire

@@ design/bsc_checker.sv @@
`default_nettype none
module bsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("invalid pressure not zero");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output waiting");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
